// File: hdl/wstc_pkg.sv
package wstc_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int ITW = $clog2(CORDIC_STEPS + 1);
    // 17-bit error scaled by 2^12, plus CORDIC growth
    localparam int CW = 32;
    localparam int ZW = 20;
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [15:0] PI_Q12 = 16'sd12868;
    localparam logic signed [31:0] GAIN_INV_Q30 = 32'sd652032874;
    localparam logic signed [12:0] ANG_MAX = 13'sd2458;
    localparam logic signed [10:0] LIN_MAX = 11'sd819;
    localparam logic [2:0] CFG_SIDE = 3'd0;
    localparam logic [2:0] CFG_POS_TOL = 3'd1;
    localparam logic [2:0] CFG_HDG_TOL = 3'd2;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
        case (i)
            5'd0: atan_q16 = 20'sd51472;
            5'd1: atan_q16 = 20'sd30386;
            5'd2: atan_q16 = 20'sd16055;
            5'd3: atan_q16 = 20'sd8150;
            5'd4: atan_q16 = 20'sd4091;
            5'd5: atan_q16 = 20'sd2047;
            5'd6: atan_q16 = 20'sd1024;
            5'd7: atan_q16 = 20'sd512;
            5'd8: atan_q16 = 20'sd256;
            5'd9: atan_q16 = 20'sd128;
            5'd10: atan_q16 = 20'sd64;
            5'd11: atan_q16 = 20'sd32;
            5'd12: atan_q16 = 20'sd16;
            5'd13: atan_q16 = 20'sd8;
            5'd14: atan_q16 = 20'sd4;
            5'd15: atan_q16 = 20'sd2;
            5'd16: atan_q16 = 20'sd1;
            default: atan_q16 = 20'sd0;
        endcase
    endfunction
endpackage

// File: hdl/wstc_if.sv
interface wstc_in_if (input logic i_clk);
    logic valid;
    logic ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] heading;
    modport source (output valid, pos_x, pos_y, heading, input ready);
    modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface wstc_out_if (input logic i_clk);
    logic valid;
    logic ready;
    logic signed [10:0] linear_cmd;
    logic signed [12:0] angular_cmd;
    logic [1:0] target_index;
    logic corner_reached;
    modport source (output valid, linear_cmd, angular_cmd, target_index, corner_reached,
                    input ready);
    modport sink (input valid, linear_cmd, angular_cmd, target_index, corner_reached,
                  output ready);
endinterface

// File: hdl/waypoint_square_tracking_control_core.sv
// Input transfer to result valid passes through S_PREP, the CORDIC iterations, S_ERR,
// S_WRAP (repeated for each heading fold, at most two), S_MUL, S_FIN and S_OUT.
// One item at a time: a new one is not accepted until the last has reached the result
// register and that register is empty; one shared add/shift CORDIC stage iterates once per
// cycle, then the gain multiply and the 10/11 decay take a step each.
// The result register holds until taken; a new item is accepted once it is empty.
// Reset (synchronous, active low): filters and corner index cleared, registers to defaults.
module waypoint_square_tracking_control_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    wstc_in_if.sink     s_in,
    wstc_out_if.source  m_out
);
    import wstc_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_PREP = 8'b00000010, S_ITER = 8'b00000100,
        S_ERR  = 8'b00001000, S_WRAP = 8'b00010000, S_MUL  = 8'b00100000,
        S_FIN  = 8'b01000000, S_OUT  = 8'b10000000
    } t_state;

    t_state r_state;
    logic signed [15:0] r_side;
    logic [14:0] r_ptol;
    logic [13:0] r_htol;
    logic signed [12:0] r_ang;
    logic signed [10:0] r_lin;
    logic [1:0] r_corner;
    logic signed [16:0] r_ex, r_ey;
    logic signed [15:0] r_hd;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [ITW-1:0] r_it;
    logic signed [17:0] r_err;
    logic signed [63:0] r_prod;
    logic r_reach, r_zero;

    logic signed [CW-1:0] dx, dy;
    logic signed [16:0] cx, cy;
    logic signed [17:0] bear, e0, ae;
    logic signed [31:0] afil;
    logic signed [17:0] ang_n;
    logic [10:0] lin_abs;
    logic [14:0] dec;
    logic [16:0] aex, aey;
    logic signed [25:0] lin_q;

    assign s_in.ready = (r_state == S_IDLE) && !m_out.valid;
    assign dx = r_y >>> r_it;
    assign dy = r_x >>> r_it;
    assign cx = (r_corner == 2'd1 || r_corner == 2'd2) ? 17'(r_side) : 17'sd0;
    assign cy = r_corner[1] ? 17'(r_side) : 17'sd0;
    assign bear = r_zero ? 18'sd0 : 18'((r_z + 20'sd8) >>> 4);
    assign e0 = bear - 18'(r_hd);
    assign ae = r_err < 0 ? -r_err : r_err;
    assign afil = (32'sd26214 * 32'(r_ang) + 32'sd16384 * 32'(r_err) + 32'sd16384) >>> 15;
    assign lin_abs = r_lin < 0 ? 11'(-r_lin) : 11'(r_lin);
    // x*10/11 via reciprocal: 10*2979/32768 with one-step correction
    assign dec = 15'(({4'd0, lin_abs} * 15'd10));
    assign aex = r_ex < 0 ? 17'(-r_ex) : 17'(r_ex);
    assign aey = r_ey < 0 ? 17'(-r_ey) : 17'(r_ey);
    assign lin_q = 26'(r_prod >>> 38);

    logic [14:0] q11;
    always_comb begin
        q11 = 15'((27'(dec) * 27'd2979) >> 15);
        if (dec - 15'(q11 * 15'd11) >= 15'd11) q11 = q11 + 15'd1;
        ang_n = afil > 32'sd2458 ? 18'sd2458 : afil < -32'sd2458 ? -18'sd2458 : 18'(afil);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_side <= 16'sd1024; r_ptol <= 15'd51; r_htol <= 14'd205;
            r_ang <= '0; r_lin <= '0; r_corner <= '0;
            m_out.valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case ({1'b0, i_cfg_idx})
                    CFG_SIDE: r_side <= i_cfg_data;
                    CFG_POS_TOL: r_ptol <= i_cfg_data[14:0];
                    CFG_HDG_TOL: r_htol <= i_cfg_data[13:0];
                    default: ;
                endcase
            end
            if (m_out.valid && m_out.ready) m_out.valid <= 1'b0;
            case (r_state)
                S_IDLE: if (s_in.valid && s_in.ready) begin
                    r_ex <= cx - 17'(s_in.pos_x);
                    r_ey <= cy - 17'(s_in.pos_y);
                    r_hd <= s_in.heading;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_zero <= (r_ex == 0) && (r_ey == 0);
                    r_reach <= (aex < 17'(r_ptol)) && (aey < 17'(r_ptol));
                    r_it <= '0;
                    if (r_ex < 0) begin
                        if (r_ey >= 0) begin
                            r_x <= CW'(r_ey) <<< 12; r_y <= -(CW'(r_ex) <<< 12);
                            r_z <= HALF_PI_Q16;
                        end else begin
                            r_x <= -(CW'(r_ey) <<< 12); r_y <= CW'(r_ex) <<< 12;
                            r_z <= -HALF_PI_Q16;
                        end
                    end else begin
                        r_x <= CW'(r_ex) <<< 12; r_y <= CW'(r_ey) <<< 12; r_z <= '0;
                    end
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    if (r_y >= 0) begin
                        r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + atan_q16(5'(r_it));
                    end else begin
                        r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - atan_q16(5'(r_it));
                    end
                    r_it <= r_it + 1'b1;
                    if (r_it == ITW'(CORDIC_STEPS - 1)) r_state <= S_ERR;
                end
                S_ERR: begin
                    r_err <= e0;
                    r_prod <= 64'(r_zero ? 32'sd0 : r_x) * 64'(GAIN_INV_Q30);
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    // bearing lies within about +-pi and heading within about +-2.5 pi: at most two folds
                    if (r_err > 18'(PI_Q12)) r_err <= r_err - 18'sd25736;
                    else if (r_err <= -18'(PI_Q12)) r_err <= r_err + 18'sd25736;
                    else r_state <= S_MUL;
                end
                S_MUL: begin
                    r_ang <= 13'(ang_n);
                    if (ae < 18'(r_htol))
                        r_lin <= lin_q > 26'sd819 ? LIN_MAX : 11'(lin_q);
                    else
                        r_lin <= r_lin < 0 ? -11'(q11) : 11'(q11);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_reach) r_corner <= r_corner + 2'd1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    m_out.linear_cmd <= r_lin;
                    m_out.angular_cmd <= r_ang;
                    m_out.target_index <= r_corner;
                    m_out.corner_reached <= r_reach;
                    m_out.valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_ang_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ang <= ANG_MAX && r_ang >= -ANG_MAX) else $error("angular out of range");
    a_lin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lin <= LIN_MAX && r_lin >= -LIN_MAX) else $error("linear out of range");
    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
endmodule
